/* rtl/imu_sfb_pkg.sv */
// Shared types and constants for the IMU sample frame builder.
// No dependencies; imported by every module of the block.
package imu_sfb_pkg;

    localparam int unsigned FRAME_WORDS    = 9;
    localparam int unsigned IDX_W          = 4;
    localparam int unsigned SAMPLE_W       = 16;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned STEP_W         = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hEE;
    localparam logic [BYTE_W-1:0] ID_BYTE      = 8'h10 | 8'h40;
    localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'h00;
    localparam logic [BYTE_W-1:0] RATE_BYTE    = 8'd25;
    localparam logic [BYTE_W-1:0] TRAIL_A_BYTE = 8'h41;
    localparam logic [BYTE_W-1:0] TRAIL_O_BYTE = 8'h4F;

    // Role of a word in the frame, decided at the front
    typedef enum logic [2:0] {
        KIND_FIRST,     // gyro x: header, then sample, restart sum
        KIND_MID,       // plain sample
        KIND_SPLIT,     // accel z: sample, then first checksum
        KIND_MAG_START, // magnetometer x: restart sum, sample
        KIND_LAST       // magnetometer z: sample, tail, checksum, trailer
    } kind_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        kind_t               kind;
    } entry_t;

endpackage

/* rtl/imu_sample_frame_builder.sv */
// Top level of the IMU sample frame builder: front, queue and back joined.
// Depends on imu_sfb_pkg, imu_sfb_front, imu_sfb_queue, imu_sfb_back.
//
// Feed nine raw sensor words per frame (gyro x,y,z, accel x,y,z, mag x,y,z)
// on the s_ side; each word is cut to 14 bits, sign-extended to 16 and sent
// high byte first inside a 28-byte frame: EE EE 50, twelve gyro/accel bytes,
// their inverted sum, six magnetometer bytes, 00, 19, the inverted sum of
// those eight bytes, then 'A' 'O' 00. The m_ side delivers one byte per
// transaction at up to one per cycle; tlast marks the last byte caused by a
// word and tuser the last byte of the frame. The single byte output register
// of the back part sets the rate: a word takes one output slot per byte it
// yields (5 for gyro x, 3 for accel z, 8 for magnetometer z, 2 otherwise),
// so a full frame streams as 28 bytes. A queue of QUEUE_DEPTH tagged words
// lets the input keep accepting while bytes drain; an accepted word goes
// into the queue first, then its first byte into the output register.
module imu_sample_frame_builder #(
    parameter int unsigned QUEUE_DEPTH = imu_sfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] raw_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_byte
    output logic        m_tlast,   // run_end
    output logic [0:0]  m_tuser    // [0] frame_end
);
    import imu_sfb_pkg::*;

    entry_t front_entry;
    entry_t head_entry;
    logic   q_full, q_empty;
    logic   in_accept;
    logic   pop;
    logic   frame_end;

    // Accept whenever the queue has room
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    imu_sfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .raw_word (s_tdata),
        .entry    (front_entry)
    );

    imu_sfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .push_entry (front_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    imu_sfb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_entry    (head_entry),
        .head_valid    (!q_empty),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (m_tdata),
        .out_run_end   (m_tlast),
        .out_frame_end (frame_end)
    );

    assign m_tuser = frame_end;

`ifndef NO_ASSERTIONS
    // Frame end always closes a word's run
    a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame end without run end");

    // Last frame byte is the trailing zero
    a_frame_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == ZERO_BYTE))
        else $error("frame end byte not zero");

    // The queue never pops while empty
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

    // A pop only ever ends a run on the output
    a_pop_marks_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_tvalid && m_tlast)
        else $error("pop without run end byte");
`endif

endmodule

/* rtl/imu_sfb_front.sv */
// Front part of the IMU sample frame builder: widens raw words and tags
// each with its place in the frame. Depends on imu_sfb_pkg.
module imu_sfb_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [imu_sfb_pkg::SAMPLE_W-1:0]  raw_word,
    output imu_sfb_pkg::entry_t               entry
);
    import imu_sfb_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    kind_t            kind;

    always_comb
    begin
        unique case (idx_reg)
            IDX_W'(0): kind = KIND_FIRST;
            IDX_W'(5): kind = KIND_SPLIT;
            IDX_W'(6): kind = KIND_MAG_START;
            IDX_W'(8): kind = KIND_LAST;
            default:   kind = KIND_MID;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            if (idx_reg == IDX_W'(FRAME_WORDS - 1))
                idx_next = '0;
            else
                idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    // Keep low 14 bits and copy bit 13 into the top two
    assign entry = {{{2{raw_word[13]}}, raw_word[13:0]}, kind};

endmodule

/* rtl/imu_sfb_queue.sv */
// Short FIFO between front and back of the IMU sample frame builder.
// Depends on imu_sfb_pkg.
module imu_sfb_queue #(
    parameter int unsigned DEPTH = imu_sfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  imu_sfb_pkg::entry_t  push_entry,
    input  logic                 pop,
    output imu_sfb_pkg::entry_t  head_entry,
    output logic                 full,
    output logic                 empty
);
    import imu_sfb_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* rtl/imu_sfb_back.sv */
// Back part of the IMU sample frame builder: walks each queued word through
// its bytes, keeps the checksum, drives the output register. Depends on imu_sfb_pkg.
module imu_sfb_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  imu_sfb_pkg::entry_t             head_entry,
    input  logic                            head_valid,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [imu_sfb_pkg::BYTE_W-1:0]  out_byte,
    output logic                            out_run_end,
    output logic                            out_frame_end
);
    import imu_sfb_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              run_end_reg;
    logic              frame_end_reg;

    logic [BYTE_W-1:0] hi, lo;
    logic [BYTE_W-1:0] byte_val;
    logic              summed, clear_sum, last_step, frame_last;
    logic              load;

    assign hi   = head_entry.sample[SAMPLE_W-1:BYTE_W];
    assign lo   = head_entry.sample[BYTE_W-1:0];
    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && last_step;

    always_comb
    begin
        byte_val   = ZERO_BYTE;
        summed     = 1'b0;
        clear_sum  = 1'b0;
        last_step  = 1'b0;
        frame_last = 1'b0;
        unique case (head_entry.kind)
            KIND_FIRST:
            begin
                case (step_reg)
                    STEP_W'(0), STEP_W'(1): byte_val = SYNC_BYTE;
                    STEP_W'(2): byte_val = ID_BYTE;
                    STEP_W'(3):
                    begin
                        byte_val  = hi;
                        summed    = 1'b1;
                        clear_sum = 1'b1;
                    end
                    default:
                    begin
                        byte_val  = lo;
                        summed    = 1'b1;
                        last_step = 1'b1;
                    end
                endcase
            end
            KIND_LAST:
            begin
                case (step_reg)
                    STEP_W'(0):
                    begin
                        byte_val = hi;
                        summed   = 1'b1;
                    end
                    STEP_W'(1):
                    begin
                        byte_val = lo;
                        summed   = 1'b1;
                    end
                    STEP_W'(2):
                    begin
                        byte_val = ZERO_BYTE;
                        summed   = 1'b1;
                    end
                    STEP_W'(3):
                    begin
                        byte_val = RATE_BYTE;
                        summed   = 1'b1;
                    end
                    STEP_W'(4): byte_val = ~sum_reg;
                    STEP_W'(5): byte_val = TRAIL_A_BYTE;
                    STEP_W'(6): byte_val = TRAIL_O_BYTE;
                    default:
                    begin
                        byte_val   = ZERO_BYTE;
                        last_step  = 1'b1;
                        frame_last = 1'b1;
                    end
                endcase
            end
            KIND_SPLIT:
            begin
                case (step_reg)
                    STEP_W'(0):
                    begin
                        byte_val = hi;
                        summed   = 1'b1;
                    end
                    STEP_W'(1):
                    begin
                        byte_val = lo;
                        summed   = 1'b1;
                    end
                    default:
                    begin
                        byte_val  = ~sum_reg;
                        last_step = 1'b1;
                    end
                endcase
            end
            default:
            begin
                // plain sample; magnetometer x also restarts the sum
                if (step_reg == '0)
                begin
                    byte_val  = hi;
                    summed    = 1'b1;
                    clear_sum = (head_entry.kind == KIND_MAG_START);
                end
                else
                begin
                    byte_val  = lo;
                    summed    = 1'b1;
                    last_step = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        sum_next   = sum_reg;
        valid_next = valid_reg;
        if (out_ready)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = last_step ? '0 : step_reg + STEP_W'(1);
            if (summed)
                sum_next = (clear_sum ? ZERO_BYTE : sum_reg) + byte_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg      <= byte_val;
            run_end_reg   <= last_step;
            frame_end_reg <= frame_last;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign out_run_end   = run_end_reg;
    assign out_frame_end = frame_end_reg;

endmodule
